### rtl/ptm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types, constants and the sequencer control store for the
// four-level page table map insert core.
// ----------------------------------------------------------------------------
package ptm_pkg;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int DEF_TABLE_SLOTS   = 64;
    localparam int DEF_FRAME_BITS    = 40;

    localparam int VPN_W             = 36;
    localparam int FRAME_W           = 40;
    localparam int CREATED_W         = 3;
    localparam int LEAF_TABLE_W      = 6;
    localparam int LEAF_ENTRY_W      = 52;

    // present and writable in the low flag bits of a leaf entry word
    localparam logic [11:0] PAGE_FLAGS = 12'h003;

    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    localparam logic STATUS_MAPPED   = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef struct packed {
        logic [VPN_W-1:0]   virt_page;
        logic [FRAME_W-1:0] phys_frame;
    } in_t;

    typedef struct packed {
        logic                    status;
        logic [CREATED_W-1:0]    created_levels;
        logic [LEAF_TABLE_W-1:0] leaf_table;
        logic [IDX_W-1:0]        leaf_slot;
        logic [LEAF_ENTRY_W-1:0] leaf_entry;
    } out_t;

    typedef enum logic [3:0] {
        STEP_CLEAR   = 4'd0,
        STEP_ACCEPT  = 4'd1,
        STEP_READ    = 4'd2,
        STEP_DESCEND = 4'd3,
        STEP_NEXT    = 4'd4,
        STEP_CHECK   = 4'd5,
        STEP_ALLOC   = 4'd6,
        STEP_LEAF    = 4'd7,
        STEP_REJECT  = 4'd8
    } step_t;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_ACCEPT  = 3'd2,
        OP_READ    = 3'd3,
        OP_DESCEND = 3'd4,
        OP_ALLOC   = 3'd5,
        OP_LEAF    = 3'd6,
        OP_REJECT  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE       = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_NO_REQ     = 3'd2,
        COND_ABSENT     = 3'd3,
        COND_DIR_LEFT   = 3'd4,
        COND_NO_SPACE   = 3'd5,
        COND_ALLOC_MORE = 3'd6,
        COND_CLEAR_LEFT = 3'd7
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        case (step)
            STEP_CLEAR:   w = '{OP_CLEAR,   COND_CLEAR_LEFT, STEP_CLEAR};
            STEP_ACCEPT:  w = '{OP_ACCEPT,  COND_NO_REQ,     STEP_ACCEPT};
            STEP_READ:    w = '{OP_READ,    COND_NONE,       STEP_READ};
            STEP_DESCEND: w = '{OP_DESCEND, COND_ABSENT,     STEP_CHECK};
            STEP_NEXT:    w = '{OP_NOP,     COND_DIR_LEFT,   STEP_READ};
            STEP_CHECK:   w = '{OP_NOP,     COND_NO_SPACE,   STEP_REJECT};
            STEP_ALLOC:   w = '{OP_ALLOC,   COND_ALLOC_MORE, STEP_ALLOC};
            STEP_LEAF:    w = '{OP_LEAF,    COND_ALWAYS,     STEP_ACCEPT};
            STEP_REJECT:  w = '{OP_REJECT,  COND_ALWAYS,     STEP_ACCEPT};
            default:      w = '{OP_NOP,     COND_ALWAYS,     STEP_ACCEPT};
        endcase
        return w;
    endfunction

    function automatic logic [IDX_W-1:0] level_index(input logic [VPN_W-1:0] vp,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_PML4: idx = vp[35:27];
            LVL_PDPT: idx = vp[26:18];
            LVL_PD:   idx = vp[17:9];
            default:  idx = vp[8:0];
        endcase
        return idx;
    endfunction

endpackage

### rtl/page_table_map_insert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_map_insert_core
// Inserts one page mapping into a four-level table store, allocating
// missing directory tables from a bump allocator.
// ----------------------------------------------------------------------------
//  channel   dir   ports                              moves
//  s_        in    s_valid s_ready s_data (in_t)      map request
//  m_        out   m_valid m_ready m_data (out_t)     status and leaf entry
//  cfg_      in    cfg_wr_en cfg_wr_data              table area frame
//
//  a request takes one store read and one test per directory level walked, then
//  one store write per allocated table and one for the leaf, all through the
//  single port pair of the table store
//  after reset a clearing pass writes every store entry, TABLE_SLOTS * 512
//  entries (32768 by default), with s_ready low; config writes are still taken
//  the next request is taken while a result waits in the output register; a
//  result that cannot be loaded because m_ready is low holds the sequencer
// ----------------------------------------------------------------------------
module page_table_map_insert_core #(
    parameter int TABLE_SLOTS = ptm_pkg::DEF_TABLE_SLOTS,
    parameter int FRAME_BITS  = ptm_pkg::DEF_FRAME_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ptm_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ptm_pkg::out_t               m_data,
    input  logic                        cfg_wr_en,
    input  logic [ptm_pkg::FRAME_W-1:0] cfg_wr_data
);

    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NF_W    = $clog2(TABLE_SLOTS + 1);
    localparam int ADDR_W  = SLOT_W + ptm_pkg::IDX_W;
    localparam int DEPTH   = TABLE_SLOTS * ptm_pkg::ENTRIES_PER_TABLE;
    localparam int ENTRY_W = FRAME_BITS + 1;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [NF_W-1:0]   SLOTS_N   = NF_W'(TABLE_SLOTS);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    ptm_pkg::step_t      pc_reg, pc_next;
    ptm_pkg::ctrl_word_t ctrl;
    logic                cond_true;
    logic                out_busy;
    logic                stall;

    ptm_pkg::in_t            req_reg, req_next;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic [1:0]              lvl_reg, lvl_next;
    logic [2:0]              created_reg, created_next;
    logic [NF_W-1:0]         next_free_reg, next_free_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    ptm_pkg::out_t           out_reg, out_next;
    logic                    m_valid_reg, m_valid_next;
    logic [ptm_pkg::FRAME_W-1:0] area_frame_reg;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]      mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;

    logic [ptm_pkg::IDX_W-1:0] lvl_idx;
    logic [FRAME_BITS-1:0]     frame;
    logic [NF_W-1:0]           free_cnt;
    logic [NF_W-1:0]           need_cnt;

    assign ctrl     = ptm_pkg::ucode_rom(pc_reg);
    assign out_busy = m_valid_reg && !m_ready;
    assign lvl_idx  = ptm_pkg::level_index(req_reg.virt_page, lvl_reg);
    assign frame    = req_reg.phys_frame[FRAME_BITS-1:0];
    assign free_cnt = SLOTS_N - next_free_reg;
    assign need_cnt = NF_W'(ptm_pkg::LVL_PT - lvl_reg);
    assign stall    = ((ctrl.op == ptm_pkg::OP_LEAF) || (ctrl.op == ptm_pkg::OP_REJECT))
                      && out_busy;

    always_comb begin
        case (ctrl.cond)
            ptm_pkg::COND_NONE:       cond_true = 1'b0;
            ptm_pkg::COND_ALWAYS:     cond_true = 1'b1;
            ptm_pkg::COND_NO_REQ:     cond_true = !s_valid;
            ptm_pkg::COND_ABSENT:     cond_true = !rd_data_reg[FRAME_BITS];
            ptm_pkg::COND_DIR_LEFT:   cond_true = (lvl_reg != ptm_pkg::LVL_PT);
            ptm_pkg::COND_NO_SPACE:   cond_true = (next_free_reg > SLOTS_N) ||
                                                  (need_cnt > free_cnt);
            ptm_pkg::COND_ALLOC_MORE: cond_true = (lvl_reg == ptm_pkg::LVL_PML4) ||
                                                  (lvl_reg == ptm_pkg::LVL_PDPT);
            ptm_pkg::COND_CLEAR_LEFT: cond_true = (clr_addr_reg != LAST_ADDR);
            default:                  cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            pc_next = pc_reg;
        end else if (cond_true) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = ptm_pkg::step_t'(pc_reg + 4'd1);
        end
    end

    always_comb begin
        s_ready        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = {cur_reg, lvl_idx};
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = {cur_reg, lvl_idx};
        req_next       = req_reg;
        cur_next       = cur_reg;
        lvl_next       = lvl_reg;
        created_next   = created_reg;
        next_free_next = next_free_reg;
        clr_addr_next  = clr_addr_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        case (ctrl.op)
            ptm_pkg::OP_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ptm_pkg::OP_ACCEPT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next     = s_data;
                    cur_next     = '0;
                    lvl_next     = ptm_pkg::LVL_PML4;
                    created_next = '0;
                end
            end
            ptm_pkg::OP_READ: begin
                mem_re = 1'b1;
            end
            ptm_pkg::OP_DESCEND: begin
                if (rd_data_reg[FRAME_BITS]) begin
                    cur_next = rd_data_reg[SLOT_W-1:0];
                    lvl_next = lvl_reg + 2'd1;
                end
            end
            ptm_pkg::OP_ALLOC: begin
                if (lvl_reg != ptm_pkg::LVL_PT) begin
                    mem_we                = 1'b1;
                    mem_wdata             = {1'b1, FRAME_BITS'(next_free_reg[SLOT_W-1:0])};
                    cur_next              = next_free_reg[SLOT_W-1:0];
                    next_free_next        = next_free_reg + NF_W'(1);
                    created_next[lvl_reg] = 1'b1;
                    lvl_next              = lvl_reg + 2'd1;
                end
            end
            ptm_pkg::OP_LEAF: begin
                if (!out_busy) begin
                    mem_we                  = 1'b1;
                    mem_waddr               = {cur_reg, req_reg.virt_page[8:0]};
                    mem_wdata               = {1'b1, frame};
                    out_next.status         = ptm_pkg::STATUS_MAPPED;
                    out_next.created_levels = created_reg;
                    out_next.leaf_table     = ptm_pkg::LEAF_TABLE_W'(cur_reg);
                    out_next.leaf_slot      = req_reg.virt_page[8:0];
                    out_next.leaf_entry     = ptm_pkg::LEAF_ENTRY_W'({frame,
                                                                      ptm_pkg::PAGE_FLAGS});
                    m_valid_next            = 1'b1;
                end
            end
            ptm_pkg::OP_REJECT: begin
                if (!out_busy) begin
                    out_next        = '0;
                    out_next.status = ptm_pkg::STATUS_NO_SPACE;
                    m_valid_next    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= ptm_pkg::STEP_CLEAR;
            clr_addr_reg   <= '0;
            next_free_reg  <= NF_W'(1);
            m_valid_reg    <= 1'b0;
            area_frame_reg <= '0;
        end else begin
            pc_reg        <= pc_next;
            clr_addr_reg  <= clr_addr_next;
            next_free_reg <= next_free_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                area_frame_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        cur_reg     <= cur_next;
        lvl_reg     <= lvl_next;
        created_reg <= created_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### rtl/ptm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_checker
// Port-level checks for the page table map insert core, bound to the top.
// ----------------------------------------------------------------------------
module ptm_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input ptm_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input ptm_pkg::out_t m_data
);

    // clearing pass keeps requests out right after reset
    a_no_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while walk in progress");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ptm_pkg::STATUS_NO_SPACE)) |->
        ((m_data.created_levels == '0) && (m_data.leaf_table == '0) &&
         (m_data.leaf_slot == '0) && (m_data.leaf_entry == '0)))
        else $error("rejected result carries nonzero fields");

    a_leaf_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ptm_pkg::STATUS_MAPPED)) |->
        (m_data.leaf_entry[1:0] == ptm_pkg::PAGE_FLAGS[1:0]))
        else $error("mapped entry missing present or writable");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind page_table_map_insert_core ptm_checker u_ptm_checker (.*);

### tb/tb_page_table_map_insert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_table_map_insert_core
// Checks the page table map insert core against a scoreboard that keeps its
// own copy of the table store and the table allocator and predicts the status
// and leaf entry of every map request. Directed requests cover zero and
// all-ones fields, remaps and partial walks. Random requests mostly reuse
// walked prefixes and run the allocator into its out-of-space case. The
// sender and receiver idle at random in the first two of three phases, and
// the table area frame register is written between phases.
// ----------------------------------------------------------------------------
module tb_page_table_map_insert_core;

    localparam int TABLE_SLOTS   = ptm_pkg::DEF_TABLE_SLOTS;
    localparam int STORE_DEPTH   = TABLE_SLOTS * ptm_pkg::ENTRIES_PER_TABLE;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 365;

    class map_scoreboard;
        bit [40:0]     table_store [STORE_DEPTH];
        int unsigned   next_free_table;
        logic [39:0]   area_frame;
        ptm_pkg::out_t expected_results [$];
        logic [26:0]   mapped_prefixes [$];
        int            errors;

        function new();
            foreach (table_store[i]) table_store[i] = '0;
            next_free_table = 1;
            area_frame      = '0;
            errors          = 0;
        endfunction

        function void set_area_frame(logic [39:0] value);
            area_frame = value;
        endfunction

        function int unsigned entry_addr(int unsigned slot, logic [8:0] idx);
            return (slot % TABLE_SLOTS) * ptm_pkg::ENTRIES_PER_TABLE + idx;
        endfunction

        function void note_request(ptm_pkg::in_t req);
            logic [8:0]    idx [4];
            int unsigned   cur;
            int unsigned   existing;
            int unsigned   need;
            int unsigned   fresh;
            int unsigned   addr;
            bit [40:0]     e;
            bit            stop;
            logic [2:0]    created;
            ptm_pkg::out_t res;
            idx[0]   = req.virt_page[35:27];
            idx[1]   = req.virt_page[26:18];
            idx[2]   = req.virt_page[17:9];
            idx[3]   = req.virt_page[8:0];
            cur      = 0;
            existing = 0;
            stop     = 0;
            created  = '0;
            res      = '0;
            for (int lvl = 0; lvl < 3; lvl++) begin
                if (!stop) begin
                    e = table_store[entry_addr(cur, idx[lvl])];
                    if (!e[40]) begin
                        stop = 1;
                    end else begin
                        cur = 32'(e[39:0] % TABLE_SLOTS);
                        existing++;
                    end
                end
            end
            need = 3 - existing;
            if (next_free_table > TABLE_SLOTS || need > TABLE_SLOTS - next_free_table) begin
                res.status = ptm_pkg::STATUS_NO_SPACE;
            end else begin
                cur = 0;
                for (int lvl = 0; lvl < 3; lvl++) begin
                    addr = entry_addr(cur, idx[lvl]);
                    e    = table_store[addr];
                    if (e[40]) begin
                        cur = 32'(e[39:0] % TABLE_SLOTS);
                    end else begin
                        fresh = next_free_table;
                        next_free_table++;
                        for (int i = 0; i < ptm_pkg::ENTRIES_PER_TABLE; i++)
                            table_store[entry_addr(fresh, i[8:0])] = '0;
                        table_store[addr] = {1'b1, 40'(fresh)};
                        created[lvl]      = 1'b1;
                        cur               = fresh;
                    end
                end
                table_store[entry_addr(cur, idx[3])] = {1'b1, req.phys_frame};
                res.status         = ptm_pkg::STATUS_MAPPED;
                res.created_levels = created;
                res.leaf_table     = cur[5:0];
                res.leaf_slot      = idx[3];
                res.leaf_entry     = {req.phys_frame, ptm_pkg::PAGE_FLAGS};
                if (created != '0)
                    mapped_prefixes.push_back(req.virt_page[35:9]);
            end
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
            if (exp_val !== act_val) begin
                $display("%0t: mismatch in %s: expected %h actual %h",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(ptm_pkg::out_t act);
            ptm_pkg::out_t exp_res;
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending: expected none actual %h",
                         $time, act);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                compare_field("status", 64'(exp_res.status), 64'(act.status));
                compare_field("created_levels", 64'(exp_res.created_levels),
                              64'(act.created_levels));
                compare_field("leaf_table", 64'(exp_res.leaf_table), 64'(act.leaf_table));
                compare_field("leaf_slot", 64'(exp_res.leaf_slot), 64'(act.leaf_slot));
                compare_field("leaf_entry", 64'(exp_res.leaf_entry), 64'(act.leaf_entry));
            end
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    ptm_pkg::in_t                s_data;
    logic                        m_valid;
    logic                        m_ready;
    ptm_pkg::out_t               m_data;
    logic                        cfg_wr_en;
    logic [ptm_pkg::FRAME_W-1:0] cfg_wr_data;

    map_scoreboard sb;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            cycle_count;

    page_table_map_insert_core #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .FRAME_BITS  (ptm_pkg::DEF_FRAME_BITS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // receiver back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input logic [35:0] vp, input logic [39:0] frame);
        ptm_pkg::in_t req;
        req.virt_page  = vp;
        req.phys_frame = frame;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
        @(negedge aclk);
    endtask

    task automatic write_area_frame(input logic [39:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_area_frame(value);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_random_requests(input int count);
        logic [35:0] vp;
        logic [39:0] frame;
        logic [26:0] prefix;
        int          r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 19))
                0:       frame = '1;
                1:       frame = '0;
                default: frame = 40'({$urandom(), $urandom()});
            endcase
            if (sb.mapped_prefixes.size() == 0 || r < 10) begin
                vp = 36'({$urandom(), $urandom()});
            end else begin
                prefix = sb.mapped_prefixes[$urandom_range(0, sb.mapped_prefixes.size() - 1)];
                if (r < 18)
                    vp = {prefix[26:18], 27'($urandom())};
                else if (r < 28)
                    vp = {prefix[26:9], 18'($urandom())};
                else
                    vp = {prefix, 9'($urandom())};
            end
            send_request(vp, frame);
        end
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_idle_pct = 27;
        recv_idle_pct = 46;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_area_frame('1);

        // directed requests
        send_request('0, '0);
        send_request('1, '1);
        send_request('0, 40'd123);
        send_request(36'd1, 40'h12_3456_789a);
        send_request({9'h000, 9'h000, 9'h000, 9'h1ff}, 40'h80_0000_0001);
        send_request({9'h000, 9'h000, 9'h001, 9'h000}, 40'h00_0000_0fff);
        send_request({9'h000, 9'h001, 9'h000, 9'h000}, 40'h7f_ffff_ffff);
        send_request({9'h1ff, 9'h1ff, 9'h1ff, 9'h000}, 40'h01_0000_0000);
        send_request('1, '0);
        send_request({9'h155, 9'h0aa, 9'h155, 9'h0aa}, 40'h55_5555_5555);
        send_request({9'h0aa, 9'h155, 9'h0aa, 9'h155}, 40'haa_aaaa_aaaa);
        send_request({9'h155, 9'h0aa, 9'h155, 9'h0aa}, 40'haa_aaaa_aaaa);

        send_random_requests(PHASE_ITEMS);
        drain_results();

        write_area_frame('0);
        send_idle_pct = 46;
        recv_idle_pct = 27;
        send_random_requests(PHASE_ITEMS);
        drain_results();

        write_area_frame(40'({$urandom(), $urandom()}));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_requests(PHASE_ITEMS);
        drain_results();

        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/ptm_pkg.sv
rtl/page_table_map_insert_core.sv
rtl/ptm_checker.sv
tb/tb_page_table_map_insert_core.sv
